@@ sv/smi_pkg.sv @@
// Shared types and constants for the small matrix inverse block.
// No dependencies; every other file in sv/ imports this package.
package smi_pkg;

   // Element format: signed fixed point, DW bits with FB fraction bits
   localparam int DW   = 32;
   localparam int FB   = 16;
   // Widths of products, cofactors, determinant and divider words
   localparam int PW   = 2 * DW;
   localparam int CW   = 2 * DW;
   localparam int PLW  = 2 * DW + 1;
   localparam int DETW = 3 * DW + 2;
   localparam int NUMW = CW + 2 * FB;
   localparam int QW   = DW + 1;
   localparam int RW   = DETW + QW;
   localparam int NEL  = 9;

   typedef enum logic [0:0] {
      FUNC_2X2 = 1'b0,
      FUNC_3X3 = 1'b1
   } func_type;

   typedef logic signed [DW-1:0]   elem_type;
   typedef logic signed [PW-1:0]   prod_type;
   typedef logic signed [CW-1:0]   cof_type;
   typedef logic signed [DETW-1:0] det_type;

   typedef struct packed {
      func_type func;
      elem_type a11;
      elem_type a21;
      elem_type a31;
      elem_type a12;
      elem_type a22;
      elem_type a32;
      elem_type a13;
      elem_type a23;
      elem_type a33;
   } req_type;

   typedef struct packed {
      elem_type r11;
      elem_type r21;
      elem_type r31;
      elem_type r12;
      elem_type r22;
      elem_type r32;
      elem_type r13;
      elem_type r23;
      elem_type r33;
      logic     singular;
      logic     saturated;
   } rsp_type;

   // Control that travels alongside the data of one word
   typedef struct packed {
      logic valid;
      logic det_zero;
   } tag_type;

   // What one divider lane hands to the merge stage
   typedef struct packed {
      elem_type value;
      logic     sat;
   } lane_res_type;

   // Cofactor j = e[CA]*e[CB] - e[CC]*e[CD], elements in column-major order
   localparam int CA [NEL] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
   localparam int CB [NEL] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
   localparam int CC [NEL] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
   localparam int CD [NEL] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

endpackage

@@ sv/smi_front.sv @@
// Front end: element products, adjugate and determinant, five register stages.
// Depends on smi_pkg.
module smi_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  smi_pkg::req_type in_word,
   output smi_pkg::tag_type tag_o,
   output smi_pkg::cof_type cof_o [smi_pkg::NEL],
   output smi_pkg::det_type det_o
);
   import smi_pkg::*;

   elem_type e_in [NEL];
   elem_type e_ff [NEL];
   func_type func1_ff;
   logic     v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   prod_type p_in [2*NEL];
   prod_type p_ff [2*NEL];
   func_type func2_ff;
   elem_type e2_ff [NEL];

   cof_type  cof3_in [NEL];
   cof_type  cof3_ff [NEL];
   func_type func3_ff;
   elem_type e3_ff [3];

   logic signed [PLW-1:0] pl_in [3];
   logic signed [PLW-1:0] pl_ff [3];
   prod_type              ph_in [3];
   prod_type              ph_ff [3];
   cof_type               cof4_ff [NEL];
   func_type              func4_ff;

   det_type det_in;
   det_type det_ff;
   logic    dz_ff;
   cof_type cof5_ff [NEL];

   // Unpack the word into column-major order
   always_comb begin
      e_in[0] = in_word.a11;
      e_in[1] = in_word.a21;
      e_in[2] = in_word.a31;
      e_in[3] = in_word.a12;
      e_in[4] = in_word.a22;
      e_in[5] = in_word.a32;
      e_in[6] = in_word.a13;
      e_in[7] = in_word.a23;
      e_in[8] = in_word.a33;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Capture the elements
   always_ff @(posedge clock) begin
      e_ff     <= e_in;
      func1_ff <= in_word.func;
   end

   // Form both products of every 2x2 minor
   always_comb begin
      for (int j = 0; j < NEL; j++) begin
         p_in[2*j]   = PW'(e_ff[CA[j]]) * PW'(e_ff[CB[j]]);
         p_in[2*j+1] = PW'(e_ff[CC[j]]) * PW'(e_ff[CD[j]]);
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      func2_ff <= func1_ff;
      e2_ff    <= e_ff;
   end

   // Subtract into cofactors; the 2x2 adjugate is just swapped and negated elements
   always_comb begin
      for (int j = 0; j < NEL; j++) begin
         cof3_in[j] = p_ff[2*j] - p_ff[2*j+1];
      end
      if (func2_ff == FUNC_2X2) begin
         for (int j = 0; j < NEL; j++) begin
            if (j != 8) cof3_in[j] = '0;
         end
         cof3_in[0] = CW'(e2_ff[4]);
         cof3_in[1] = -CW'(e2_ff[1]);
         cof3_in[3] = -CW'(e2_ff[3]);
         cof3_in[4] = CW'(e2_ff[0]);
      end
   end

   // In 2x2 mode the bottom-right entry carries the determinant until the last stage
   always_ff @(posedge clock) begin
      cof3_ff  <= cof3_in;
      func3_ff <= func2_ff;
      e3_ff[0] <= e2_ff[0];
      e3_ff[1] <= e2_ff[3];
      e3_ff[2] <= e2_ff[6];
   end

   // Expand along the first row: split each cofactor into halves to keep multipliers narrow
   always_comb begin
      for (int t = 0; t < 3; t++) begin
         pl_in[t] = PLW'(e3_ff[t]) * PLW'($signed({1'b0, cof3_ff[t][DW-1:0]}));
         ph_in[t] = PW'(e3_ff[t]) * PW'($signed(cof3_ff[t][CW-1:DW]));
      end
   end

   always_ff @(posedge clock) begin
      pl_ff    <= pl_in;
      ph_ff    <= ph_in;
      cof4_ff  <= cof3_ff;
      func4_ff <= func3_ff;
   end

   // Sum the partial products and pick the determinant for the mode
   always_comb begin
      det_in = '0;
      for (int t = 0; t < 3; t++) begin
         det_in = det_in + (DETW'(ph_ff[t]) <<< DW) + DETW'(pl_ff[t]);
      end
      if (func4_ff == FUNC_2X2) det_in = DETW'(cof4_ff[8]);
   end

   // Drop the determinant from the bottom-right slot in 2x2 mode
   always_ff @(posedge clock) begin
      det_ff  <= det_in;
      dz_ff   <= (det_in == '0);
      for (int j = 0; j < NEL - 1; j++) cof5_ff[j] <= cof4_ff[j];
      cof5_ff[NEL-1] <= (func4_ff == FUNC_2X2) ? '0 : cof4_ff[NEL-1];
   end

   assign tag_o.valid    = v5_ff;
   assign tag_o.det_zero = dz_ff;
   assign cof_o          = cof5_ff;
   assign det_o          = det_ff;

endmodule

@@ sv/smi_lane.sv @@
// One divider lane: pipelined restoring division of cofactor * 2^(2*FB) by the determinant,
// one quotient bit a stage, then saturation. Depends on smi_pkg.
module smi_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  smi_pkg::tag_type      tag_i,
   input  smi_pkg::cof_type      cof_i,
   input  smi_pkg::det_type      det_i,
   output smi_pkg::tag_type      tag_o,
   output smi_pkg::lane_res_type res_o
);
   import smi_pkg::*;

   logic [CW-1:0]   cabs;
   logic [DETW-1:0] dabs;
   logic [NUMW-1:0] num;

   logic [RW-1:0]   rem_ff [QW+1];
   logic [DETW-1:0] den_ff [QW+1];
   logic [QW-1:0]   q_ff   [QW+1];
   logic            neg_ff [QW+1];
   logic            cz_ff  [QW+1];
   logic            ovf_ff [QW+1];
   logic            dz_ff  [QW+1];
   logic            vld_ff [QW+1];

   logic [QW-1:0]   lim;
   logic            sat;
   logic [QW-1:0]   mag;
   lane_res_type    res_in;
   lane_res_type    res_ff;
   tag_type         tag_ff;

   // Take magnitudes and line up the numerator
   always_comb begin
      cabs = cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
      dabs = det_i[DETW-1] ? DETW'(-det_i) : DETW'(det_i);
      num  = {cabs, (2*FB)'(0)};
   end

   // Valid bits through the lane; the output tag travels with them
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QW; s++) vld_ff[s] <= 1'b0;
         tag_ff.valid    <= 1'b0;
         tag_ff.det_zero <= 1'b0;
      end else begin
         vld_ff[0] <= tag_i.valid;
         for (int s = 1; s <= QW; s++) vld_ff[s] <= vld_ff[s-1];
         tag_ff.valid    <= vld_ff[QW];
         tag_ff.det_zero <= dz_ff[QW];
      end
   end

   // Prepare: flag quotients that cannot fit the QW-bit register
   always_ff @(posedge clock) begin
      rem_ff[0] <= RW'(num);
      den_ff[0] <= dabs;
      q_ff[0]   <= '0;
      neg_ff[0] <= cof_i[CW-1] ^ det_i[DETW-1];
      cz_ff[0]  <= (cof_i == '0);
      ovf_ff[0] <= RW'(num) >= (RW'(dabs) << QW);
      dz_ff[0]  <= tag_i.det_zero;
   end

   // One quotient bit per stage, most significant first
   for (genvar s = 0; s < QW; s++) begin : g_step
      localparam int K = QW - 1 - s;
      logic [RW-1:0] dsh;
      logic          take;

      always_comb begin
         dsh  = RW'(den_ff[s]) << K;
         take = rem_ff[s] >= dsh;
      end

      always_ff @(posedge clock) begin
         rem_ff[s+1] <= take ? (rem_ff[s] - dsh) : rem_ff[s];
         q_ff[s+1]   <= {q_ff[s][QW-2:0], take};
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
         cz_ff[s+1]  <= cz_ff[s];
         ovf_ff[s+1] <= ovf_ff[s];
         dz_ff[s+1]  <= dz_ff[s];
      end
   end

   // Clip to the signed range and restore the sign
   always_comb begin
      lim = neg_ff[QW] ? (QW'(1) << (DW - 1)) : ((QW'(1) << (DW - 1)) - QW'(1));
      sat = !cz_ff[QW] && (ovf_ff[QW] || (q_ff[QW] > lim));
      mag = sat ? lim : q_ff[QW];
      res_in.value = neg_ff[QW] ? DW'(-mag) : DW'(mag);
      res_in.sat   = sat;
      if (cz_ff[QW]) res_in.value = '0;
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign tag_o = tag_ff;
   assign res_o = res_ff;

endmodule

@@ sv/small_matrix_inverse.sv @@
// Top level of the small matrix inverse: front end, nine divider lanes and the merge stage.
// Depends on smi_pkg, smi_front and smi_lane.
//
//   channel   ports                          direction   transfer
//   request   start, busy, req_data          in          start high while busy low
//   result    rsp_strobe, rsp_data           out         one cycle per strobe, no stall
//
// One word is accepted every cycle; busy is always low.
// The pipe has 5 front-end stages, 2 + DW + 1 lane stages (one quotient bit per stage
// over DW+1 bits) and 1 merge stage.
// Reset clears only the valid pipeline; words in flight are dropped.
// The receiver cannot stall, so no backpressure exists anywhere in the pipe.
module small_matrix_inverse (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  smi_pkg::req_type req_data,
   output logic             rsp_strobe,
   output smi_pkg::rsp_type rsp_data
);
   import smi_pkg::*;

   tag_type      front_tag;
   cof_type      front_cof [NEL];
   det_type      front_det;
   tag_type      lane_tag [NEL];
   lane_res_type lane_res [NEL];

   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    strobe_ff;
   logic    any_sat;

   assign busy = 1'b0;

   smi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .in_word  (req_data),
      .tag_o    (front_tag),
      .cof_o    (front_cof),
      .det_o    (front_det)
   );

   for (genvar j = 0; j < NEL; j++) begin : g_lane
      smi_lane u_lane (
         .clock (clock),
         .reset (reset),
         .tag_i (front_tag),
         .cof_i (front_cof[j]),
         .det_i (front_det),
         .tag_o (lane_tag[j]),
         .res_o (lane_res[j])
      );
   end

   // Merge lanes and OR their saturation flags; on a singular matrix zero the word and set only singular
   always_comb begin
      any_sat = 1'b0;
      for (int j = 0; j < NEL; j++) any_sat = any_sat | lane_res[j].sat;
      rsp_in.r11       = lane_res[0].value;
      rsp_in.r21       = lane_res[1].value;
      rsp_in.r31       = lane_res[2].value;
      rsp_in.r12       = lane_res[3].value;
      rsp_in.r22       = lane_res[4].value;
      rsp_in.r32       = lane_res[5].value;
      rsp_in.r13       = lane_res[6].value;
      rsp_in.r23       = lane_res[7].value;
      rsp_in.r33       = lane_res[8].value;
      rsp_in.singular  = 1'b0;
      rsp_in.saturated = any_sat;
      if (lane_tag[0].det_zero) begin
         rsp_in           = '0;
         rsp_in.singular  = 1'b1;
      end
   end

   // Hold the result word for its single strobe cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= lane_tag[0].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
